FILE: sv/tpsb_pkg.sv
`timescale 1ns / 1ps
package tpsb_pkg;

    localparam int FRAC_BITS = 8;
    localparam int FW        = FRAC_BITS + 1;
    localparam int LIN_W     = 17;
    localparam int TOP_W     = LIN_W + FW;
    localparam int ACC_W     = LIN_W + 2 * FW;
    localparam int RES_W     = LIN_W + 1;
    localparam int Q_W       = 18;
    localparam int ROOT_W    = Q_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CH    = 4;

    localparam logic [LIN_W-1:0] ONE_Q16 = LIN_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_ALPHA = CFG_IDX_W'(3);

    // channel order: red, green, blue, alpha
    localparam int CH_ALPHA = 3;

    typedef logic [255:0][LIN_W-1:0]       t_lin_tab;
    typedef logic [NUM_CH-1:0][LIN_W-1:0]  t_lin4;

    typedef struct packed {
        logic [2:0][LIN_W-1:0] rgb;
        logic [LIN_W-1:0]      alpha;
    } t_tint;

    function automatic t_lin_tab f_build_rgb();
        t_lin_tab t;
        longint   v;
        for (int c = 0; c < 256; c++) begin
            v = (longint'(c) * c * 65536 + 32512) / 65025;
            t[c] = LIN_W'(v);
        end
        return t;
    endfunction

    function automatic t_lin_tab f_build_alpha();
        t_lin_tab t;
        longint   v;
        for (int c = 0; c < 256; c++) begin
            v = (longint'(c) * 65536 + 127) / 255;
            t[c] = LIN_W'(v);
        end
        return t;
    endfunction

    localparam t_lin_tab LIN_RGB   = f_build_rgb();
    localparam t_lin_tab LIN_ALPHA = f_build_alpha();

    function automatic logic [LIN_W-1:0] f_clamp_one(logic [LIN_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic logic [LIN_W-1:0] f_mul_q16(logic [LIN_W-1:0] a,
                                                   logic [LIN_W-1:0] b);
        logic [2*LIN_W-1:0] p;
        p = {{LIN_W{1'b0}}, a} * {{LIN_W{1'b0}}, b} + (2*LIN_W)'(32768);
        return p[LIN_W+15:16];
    endfunction

    // linearize one byte of a packed ARGB word
    function automatic logic [LIN_W-1:0] f_lin(logic [31:0] px, int ch);
        logic [LIN_W-1:0] v;
        unique case (ch)
            0:       v = LIN_RGB[px[23:16]];
            1:       v = LIN_RGB[px[15:8]];
            2:       v = LIN_RGB[px[7:0]];
            default: v = LIN_ALPHA[px[31:24]];
        endcase
        return v;
    endfunction

endpackage

FILE: sv/tpsb_cfg.sv
`timescale 1ns / 1ps
module tpsb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [tpsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpsb_pkg::LIN_W-1:0]     i_cfg_data,
    output tpsb_pkg::t_tint                o_tint
);
    import tpsb_pkg::*;

    logic [LIN_W-1:0] r_red, r_green, r_blue, r_alpha;
    t_tint            r_tint;
    t_tint            n_tint;
    logic [LIN_W-1:0] w_ta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= ONE_Q16;
            r_green <= ONE_Q16;
            r_blue  <= ONE_Q16;
            r_alpha <= ONE_Q16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TINT_RED:   r_red   <= i_cfg_data;
                CFG_TINT_GREEN: r_green <= i_cfg_data;
                CFG_TINT_BLUE:  r_blue  <= i_cfg_data;
                CFG_TINT_ALPHA: r_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // premultiply tint RGB by tint alpha
    always_comb begin
        w_ta          = f_clamp_one(r_alpha);
        n_tint.alpha  = w_ta;
        n_tint.rgb[0] = f_mul_q16(f_clamp_one(r_red), w_ta);
        n_tint.rgb[1] = f_mul_q16(f_clamp_one(r_green), w_ta);
        n_tint.rgb[2] = f_mul_q16(f_clamp_one(r_blue), w_ta);
    end

    always_ff @(posedge i_clk) begin
        r_tint <= n_tint;
    end

    assign o_tint = r_tint;

endmodule

FILE: sv/tpsb_filter.sv
`timescale 1ns / 1ps
module tpsb_filter (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [3:0][31:0]      i_texel,
    input  logic [7:0]            i_frac_x,
    input  logic [7:0]            i_frac_y,
    input  logic [31:0]           i_dest,
    output tpsb_pkg::t_lin4       o_f,
    output logic [31:0]           o_dest
);
    import tpsb_pkg::*;

    localparam logic [FW-1:0] FMASK  = FW'((1 << FRAC_BITS) - 1);
    localparam logic [FW-1:0] S      = FW'(1 << FRAC_BITS);
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);

    t_lin4                      r_lin [4];
    logic [FW-1:0]              r_fx1, r_fy1, r_fy2;
    logic [31:0]                r_dst1, r_dst2, r_dst3;
    logic [NUM_CH-1:0][TOP_W-1:0] r_top, r_bot, n_top, n_bot;
    t_lin4                      r_f, n_f;
    logic [ACC_W-1:0]           w_acc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int t = 0; t < 4; t++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_lin[t][c] <= f_lin(i_texel[t], c);
                end
            end
            r_fx1  <= FW'(i_frac_x) & FMASK;
            r_fy1  <= FW'(i_frac_y) & FMASK;
            r_dst1 <= i_dest;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_top[c] = TOP_W'(r_lin[0][c]) * TOP_W'(S - r_fx1)
                     + TOP_W'(r_lin[1][c]) * TOP_W'(r_fx1);
            n_bot[c] = TOP_W'(r_lin[2][c]) * TOP_W'(S - r_fx1)
                     + TOP_W'(r_lin[3][c]) * TOP_W'(r_fx1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top  <= n_top;
            r_bot  <= n_bot;
            r_fy2  <= r_fy1;
            r_dst2 <= r_dst1;
        end
    end

    always_comb begin
        w_acc = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            w_acc = ACC_W'(r_top[c]) * ACC_W'(S - r_fy2)
                  + ACC_W'(r_bot[c]) * ACC_W'(r_fy2) + HALF;
            n_f[c] = w_acc[2*FRAC_BITS +: LIN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f    <= n_f;
            r_dst3 <= r_dst2;
        end
    end

    assign o_f    = r_f;
    assign o_dest = r_dst3;

endmodule

FILE: sv/tpsb_blend.sv
`timescale 1ns / 1ps
module tpsb_blend (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  tpsb_pkg::t_lin4                 i_f,
    input  logic [31:0]                     i_dest,
    input  tpsb_pkg::t_tint                 i_tint,
    output logic [2:0][tpsb_pkg::Q_W-1:0]   o_q,
    output logic [7:0]                      o_alpha
);
    import tpsb_pkg::*;

    localparam int PQ_W = RES_W + 18;

    t_lin4                    r_src, n_src;
    t_lin4                    r_dlin;
    logic [2:0][RES_W-1:0]    r_res, n_res;
    logic [RES_W-1:0]         r_res_a, n_res_a;
    logic [LIN_W-1:0]         w_om;
    logic [2:0][Q_W-1:0]      r_q, n_q;
    logic [7:0]               r_a, n_a;
    logic [PQ_W-1:0]          w_pq;
    logic [RES_W+8:0]         w_pa;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_src[c] = f_clamp_one(f_mul_q16(i_f[c], i_tint.rgb[c]));
        end
        n_src[CH_ALPHA] = f_clamp_one(f_mul_q16(i_f[CH_ALPHA], i_tint.alpha));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_src <= n_src;
            for (int c = 0; c < NUM_CH; c++) begin
                r_dlin[c] <= f_lin(i_dest, c);
            end
        end
    end

    // source over: src + dst * (1 - src alpha)
    always_comb begin
        w_om = ONE_Q16 - r_src[CH_ALPHA];
        for (int c = 0; c < 3; c++) begin
            n_res[c] = RES_W'(r_src[c]) + RES_W'(f_mul_q16(r_dlin[c], w_om));
        end
        n_res_a = RES_W'(r_src[CH_ALPHA]) + RES_W'(f_mul_q16(r_dlin[CH_ALPHA], w_om));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res   <= n_res;
            r_res_a <= n_res_a;
        end
    end

    // scale RGB by 4*255^2 for the square root and round alpha to 8 bits; clamps keep both saturated
    always_comb begin
        w_pq = '0;
        for (int c = 0; c < 3; c++) begin
            w_pq   = PQ_W'(r_res[c]) * PQ_W'(260100);
            n_q[c] = (w_pq[PQ_W-1:16] > (PQ_W-16)'((1 << Q_W) - 1))
                   ? {Q_W{1'b1}} : w_pq[16 +: Q_W];
        end
        w_pa = (RES_W+9)'(r_res_a) * (RES_W+9)'(255) + (RES_W+9)'(32768);
        n_a  = (w_pa[RES_W+8:16] > (RES_W-7)'(255)) ? 8'hFF : w_pa[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
            r_a <= n_a;
        end
    end

    assign o_q     = r_q;
    assign o_alpha = r_a;

endmodule

FILE: sv/tpsb_sqrt.sv
`timescale 1ns / 1ps
module tpsb_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [2:0][tpsb_pkg::Q_W-1:0]  i_q,
    input  logic [7:0]                     i_alpha,
    output logic [31:0]                    o_pixel
);
    import tpsb_pkg::*;

    localparam int NSTG = 3;
    localparam int SPS  = ROOT_W / NSTG;

    logic [2:0][REM_W-1:0]  r_rem  [NSTG];
    logic [2:0][ROOT_W-1:0] r_root [NSTG];
    logic [2:0][Q_W-1:0]    r_q    [NSTG];
    logic [7:0]             r_a    [NSTG];
    logic [2:0][7:0]        w_n;
    logic [ROOT_W:0]        w_m1;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [2:0][REM_W-1:0]  n_rem;
        logic [2:0][ROOT_W-1:0] n_root;
        logic [2:0][Q_W-1:0]    w_qi;
        logic [7:0]             w_ai;
        logic [REM_W-1:0]       w_t;

        // SPS digits of the restoring square root per stage
        always_comb begin
            w_t = '0;
            for (int l = 0; l < 3; l++) begin
                if (s == 0) begin
                    n_rem[l]  = '0;
                    n_root[l] = '0;
                    w_qi[l]   = i_q[l];
                end else begin
                    n_rem[l]  = r_rem[(s == 0) ? 0 : s-1][l];
                    n_root[l] = r_root[(s == 0) ? 0 : s-1][l];
                    w_qi[l]   = r_q[(s == 0) ? 0 : s-1][l];
                end
                for (int j = 0; j < SPS; j++) begin
                    n_rem[l] = {n_rem[l][REM_W-3:0],
                                w_qi[l][2*(ROOT_W-1-s*SPS-j) +: 2]};
                    w_t = {1'b0, n_root[l], 2'b01};
                    if (n_rem[l] >= w_t) begin
                        n_rem[l]  = n_rem[l] - w_t;
                        n_root[l] = {n_root[l][ROOT_W-2:0], 1'b1};
                    end else begin
                        n_root[l] = {n_root[l][ROOT_W-2:0], 1'b0};
                    end
                end
            end
            w_ai = (s == 0) ? i_alpha : r_a[(s == 0) ? 0 : s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_q[s]    <= w_qi;
                r_a[s]    <= w_ai;
            end
        end
    end

    // round half up from twice the value, saturate to 255
    always_comb begin
        w_m1 = '0;
        for (int l = 0; l < 3; l++) begin
            w_m1   = (ROOT_W+1)'(r_root[NSTG-1][l]) + (ROOT_W+1)'(1);
            w_n[l] = w_m1[ROOT_W] ? 8'hFF : w_m1[ROOT_W-1:1];
        end
    end

    assign o_pixel = {r_a[NSTG-1], w_n[0], w_n[1], w_n[2]};

endmodule

FILE: sv/textured_pixel_shade_and_blend_top.sv
`timescale 1ns / 1ps
// Bilinear texture filter with gamma-2 linearization, premultiplied tint
// and source-over blend, one pixel per word.
// Input channel: i_valid / o_stall with four ARGB texels, two 8-bit
// fractions and the destination pixel. A word is taken at each edge with
// i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the blended ARGB pixel.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
// selects tint red, green, blue, alpha; other indexes are dropped. Write
// only while the pipeline is empty; a write takes effect through the tint
// register and the registered premultiplied tint. A word passes the 9-stage
// pipeline (lookup, two filter stages, tint, blend, scale, three square-root
// stages) before o_valid rises. Throughput: one pixel per clock while the
// receiver does not stall.
// Reset: synchronous, active low; clears all stage valids and sets each
// tint register to one.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and o_stall rises in the same cycle; nothing is dropped or repeated.
module textured_pixel_shade_and_blend_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [31:0]                    i_texel_top_left,
    input  logic [31:0]                    i_texel_top_right,
    input  logic [31:0]                    i_texel_bottom_left,
    input  logic [31:0]                    i_texel_bottom_right,
    input  logic [7:0]                     i_frac_x,
    input  logic [7:0]                     i_frac_y,
    input  logic [31:0]                    i_dest_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [31:0]                    o_blended_pixel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpsb_pkg::LIN_W-1:0]     i_cfg_data
);
    import tpsb_pkg::*;

    localparam int DEPTH = 9;

    logic [DEPTH-1:0]    r_v;
    logic                w_en;
    t_tint               w_tint;
    t_lin4               w_f;
    logic [31:0]         w_dest;
    logic [2:0][Q_W-1:0] w_q;
    logic [7:0]          w_alpha;

    assign w_en        = !(r_v[DEPTH-1] && i_stall);
    assign o_stall     = !w_en;
    assign o_valid     = r_v[DEPTH-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
    end

    tpsb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tint      (w_tint)
    );

    tpsb_filter u_filter (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_texel  ({i_texel_bottom_right, i_texel_bottom_left,
                    i_texel_top_right, i_texel_top_left}),
        .i_frac_x (i_frac_x),
        .i_frac_y (i_frac_y),
        .i_dest   (i_dest_pixel),
        .o_f      (w_f),
        .o_dest   (w_dest)
    );

    tpsb_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_f     (w_f),
        .i_dest  (w_dest),
        .i_tint  (w_tint),
        .o_q     (w_q),
        .o_alpha (w_alpha)
    );

    tpsb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_q     (w_q),
        .i_alpha (w_alpha),
        .o_pixel (o_blended_pixel)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a blocked output word");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_v))
        else $error("stage valids moved while stalled");

    a_shift_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (r_v[0] == $past(i_valid)))
        else $error("accepted word not entered in first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

FILE: test/tb_textured_pixel_shade_and_blend_top.sv
`timescale 1ns / 1ps
module tb_textured_pixel_shade_and_blend_top;
    import tpsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 30;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [31:0]          i_texel_top_left;
    logic [31:0]          i_texel_top_right;
    logic [31:0]          i_texel_bottom_left;
    logic [31:0]          i_texel_bottom_right;
    logic [7:0]           i_frac_x;
    logic [7:0]           i_frac_y;
    logic [31:0]          i_dest_pixel;
    logic                 o_valid;
    logic                 i_stall;
    logic [31:0]          o_blended_pixel;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LIN_W-1:0]     i_cfg_data;

    textured_pixel_shade_and_blend_top uut (.*);

    // local copy of the tint registers
    logic [16:0] tint_r, tint_g, tint_b, tint_a;
    logic [31:0] blend_queue[$];
    int          mismatch_count;
    int          idle_cycles;
    int          pixels_sent;
    int          pixels_seen;
    bit          sink_busy_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_one(longint v);
        return (v > 65536) ? 65536 : v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic longint gamma_in(longint c);
        return (c * c * 65536 + 32512) / 65025;
    endfunction

    function automatic longint alpha_in(longint a);
        return (a * 65536 + 127) / 255;
    endfunction

    function automatic longint filter4(longint tl, longint tr, longint bl, longint br,
                                       longint fx, longint fy);
        longint s;
        longint acc;
        s   = 256;
        acc = (tl * (s - fx) + tr * fx) * (s - fy) + (bl * (s - fx) + br * fx) * fy;
        return (acc + 32768) >>> 16;
    endfunction

    function automatic longint int_sqrt(longint t);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > t) b = b >> 2;
        while (b != 0) begin
            if (t >= r + b) begin
                t = t - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] gamma_out(longint x);
        longint m;
        longint n;
        m = int_sqrt(260100 * x) >>> 8;
        n = (m + 1) >>> 1;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic logic [31:0] shade_pixel(logic [31:0] tl, logic [31:0] tr,
                                                logic [31:0] bl, logic [31:0] br,
                                                logic [7:0] fx, logic [7:0] fy,
                                                logic [31:0] dst);
        longint     ta;
        longint     tint[3];
        longint     src[4];
        longint     res;
        longint     f;
        int         sh;
        logic [7:0] ch[4];
        ta      = sat_one(tint_a);
        tint[0] = qmul(sat_one(tint_r), ta);
        tint[1] = qmul(sat_one(tint_g), ta);
        tint[2] = qmul(sat_one(tint_b), ta);
        for (int i = 0; i < 3; i++) begin
            sh = 16 - 8 * i;
            f = filter4(gamma_in((tl >> sh) & 8'hFF), gamma_in((tr >> sh) & 8'hFF),
                        gamma_in((bl >> sh) & 8'hFF), gamma_in((br >> sh) & 8'hFF),
                        fx, fy);
            src[i] = sat_one(qmul(f, tint[i]));
        end
        src[3] = sat_one(qmul(filter4(alpha_in(tl[31:24]), alpha_in(tr[31:24]),
                                      alpha_in(bl[31:24]), alpha_in(br[31:24]),
                                      fx, fy), ta));
        for (int i = 0; i < 3; i++) begin
            sh = 16 - 8 * i;
            res = src[i] + qmul(gamma_in((dst >> sh) & 8'hFF), 65536 - src[3]);
            ch[i] = gamma_out(res);
        end
        res = src[3] + qmul(alpha_in(dst[31:24]), 65536 - src[3]);
        res = (255 * res + 32768) >>> 16;
        ch[3] = (res > 255) ? 8'd255 : res[7:0];
        return {ch[3], ch[0], ch[1], ch[2]};
    endfunction

    // drop valid only for a real gap, so back to back words get one update
    task automatic send_pixel(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                              logic [31:0] br, logic [7:0] fx, logic [7:0] fy,
                              logic [31:0] dst, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_texel_top_left     <= tl;
        i_texel_top_right    <= tr;
        i_texel_bottom_left  <= bl;
        i_texel_bottom_right <= br;
        i_frac_x             <= fx;
        i_frac_y             <= fy;
        i_dest_pixel         <= dst;
        blend_queue.push_back(shade_pixel(tl, tr, bl, br, fx, fy, dst));
        pixels_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random(int count, bit well_mixed);
        logic [31:0] t0, t1, t2, t3;
        for (int n = 0; n < count; n++) begin
            t0 = $urandom;
            t1 = $urandom;
            t2 = $urandom;
            t3 = $urandom;
            // flat texture patch now and then, exercises filter weight sums
            if (well_mixed && $urandom_range(3) == 0) begin
                t1 = t0;
                t2 = t0;
                t3 = t0;
            end
            send_pixel(t0, t1, t2, t3, 8'($urandom), 8'($urandom), $urandom,
                       ($urandom_range(3) == 0) ? 0 : $urandom_range(11));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tint(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TINT_RED:   tint_r = val;
            CFG_TINT_GREEN: tint_g = val;
            CFG_TINT_BLUE:  tint_b = val;
            CFG_TINT_ALPHA: tint_a = val;
            default:        ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_tint(logic [16:0] r, logic [16:0] g, logic [16:0] b,
                            logic [16:0] a);
        write_tint(CFG_TINT_RED, r);
        write_tint(CFG_TINT_GREEN, g);
        write_tint(CFG_TINT_BLUE, b);
        write_tint(CFG_TINT_ALPHA, a);
    endtask

    task automatic test_directed();
        send_pixel(0, 0, 0, 0, 0, 0, 0, 0);
        send_pixel('1, '1, '1, '1, 8'hFF, 8'hFF, '1, 0);
        send_pixel('1, 0, 0, 0, 0, 0, 32'h80808080, 0);
        send_pixel(0, '1, 0, 0, 8'hFF, 0, 32'h00FF00FF, 1);
        send_pixel(0, 0, '1, 0, 0, 8'hFF, 32'hFF000000, 0);
        send_pixel(0, 0, 0, '1, 8'hFF, 8'hFF, 32'h00FFFFFF, 0);
        send_pixel(32'hFF102030, 32'h80FF00FF, 32'h00AA55AA, 32'h7F7F7F7F,
                   8'h80, 8'h80, 32'h12345678, 2);
        send_pixel(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF,
                   8'h01, 8'hFE, '1, 0);
        send_pixel(32'h01010101, 32'hFEFEFEFE, 32'h55555555, 32'hAAAAAAAA,
                   8'h55, 8'hAA, 32'h55AA55AA, 0);
        send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   8'h40, 8'hC0, 32'hFFFFFFFF, 0);
    endtask

    task automatic test_tint_settings();
        // above-one values saturate, index beyond the list is dropped
        set_tint(17'h1FFFF, 17'h10001, 17'h18000, 17'h1FFFF);
        write_tint(3'd4, 17'd0);
        write_tint(3'd7, 17'h0AAAA);
        send_random(20, 1'b1);
        wait_drained();
        set_tint(0, 0, 0, 0);
        send_random(20, 1'b0);
        wait_drained();
        set_tint(17'h08000, 17'h04000, 17'h0C000, 17'h10000);
        send_random(20, 1'b1);
        wait_drained();
        set_tint(17'h10000, 17'h10000, 17'h10000, 17'h00001);
        send_random(20, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_tints();
        for (int phase = 0; phase < 6; phase++) begin
            set_tint(17'($urandom_range(65536)), 17'($urandom_range(65536)),
                     17'($urandom_range(65536)), 17'($urandom_range(65536)));
            send_random(110, 1'b1);
            wait_drained();
        end
        set_tint(17'h10000, 17'h10000, 17'h10000, 17'h10000);
    endtask

    task automatic test_back_to_back();
        sink_busy_mode = 1'b0;
        for (int n = 0; n < 60; n++)
            send_pixel($urandom, $urandom, $urandom, $urandom, 8'($urandom),
                       8'($urandom), $urandom, 0);
        wait_drained();
        sink_busy_mode = 1'b1;
    endtask

    // result checker
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            pixels_seen++;
            if (blend_queue.size() == 0) begin
                $error("blended_pixel: unexpected word 0x%08h", o_blended_pixel);
                mismatch_count++;
            end else begin
                want = blend_queue.pop_front();
                if (o_blended_pixel !== want) begin
                    $error("blended_pixel: expected 0x%08h actual 0x%08h",
                           want, o_blended_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver stall in busy mode: wait a random count per word, sometimes none at all
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_stall) begin
                if (hold == 0) i_stall <= 1'b0;
                else hold--;
            end else if (o_valid && sink_busy_mode) begin
                hold = $urandom_range(11);
                if (hold != 0) begin
                    i_stall <= 1'b1;
                    hold--;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_textured_pixel_shade_and_blend_top: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_texel_top_left     = '0;
        i_texel_top_right    = '0;
        i_texel_bottom_left  = '0;
        i_texel_bottom_right = '0;
        i_frac_x             = '0;
        i_frac_y             = '0;
        i_dest_pixel         = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_index          = '0;
        i_cfg_data           = '0;
        tint_r               = 17'h10000;
        tint_g               = 17'h10000;
        tint_b               = 17'h10000;
        tint_a               = 17'h10000;
        mismatch_count       = 0;
        idle_cycles          = 0;
        pixels_sent          = 0;
        pixels_seen          = 0;
        sink_busy_mode       = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_tint_settings();
        test_back_to_back();
        test_random_tints();
        wait_drained();

        $display("Covered %0d pixels (%0d checked) over directed texels, tint extremes",
                 pixels_sent, pixels_seen);
        $display("and random tints with random gaps and output stalls.");
        if (mismatch_count == 0 && blend_queue.size() == 0) begin
            $display("tb_textured_pixel_shade_and_blend_top: clean");
        end else begin
            $display("tb_textured_pixel_shade_and_blend_top: errors");
        end
        $finish;
    end

endmodule
